@@ hw/rtl/quantized_depthwise_mac_requant_assert.svh @@
// assertion macros for the depthwise mac and requantizer checker
// depends on a clk and an active-low rst_n in the scope of use
`ifndef QUANTIZED_DEPTHWISE_MAC_REQUANT_ASSERT_SVH
`define QUANTIZED_DEPTHWISE_MAC_REQUANT_ASSERT_SVH

// clocked check, off while reset is asserted
`define QDMR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define QDMR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/qdmr_pkg.sv @@
// shared types and constants for the depthwise mac and requantizer
// used by qdmr_ctrl, qdmr_dp and the top level
package qdmr_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_DATA_MODE   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_INPUT_ZP    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_WEIGHT_ZP   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_OUTPUT_ZP   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_BIAS_ENABLE = 3'd4;

  localparam logic [1:0] MODE_UNSIGNED = 2'd0;
  localparam logic [1:0] MODE_SIGNED   = 2'd1;
  localparam logic [1:0] MODE_U_IN_S_W = 2'd2;

  localparam int unsigned InDataW  = 88;
  localparam int unsigned OutDataW = 8;
  localparam int unsigned CfgDataW = 9;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_PROD,
    ACC_BIAS,
    ACC_CLEAR
  } acc_op_t;

  typedef enum logic [2:0] {
    ST_TAP,
    ST_LASTP,
    ST_BIAS,
    ST_SHL,
    ST_MUL,
    ST_HM,
    ST_RND,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic    tap_load;
    acc_op_t acc_op;
    logic    a_load;
    logic    mul_en;
    logic    hm_en;
    logic    rnd_en;
    logic    out_load;
  } dp_cmd_t;

endpackage

@@ hw/rtl/qdmr_ctrl.sv @@
// controller state machine: tap handshake, requant sequence, output beat
// depends on qdmr_pkg
module qdmr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tlast,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output qdmr_pkg::dp_cmd_t cmd
);

  qdmr_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qdmr_pkg::ST_TAP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_tready    = 1'b0;
    accept       = 1'b0;
    cmd          = '0;
    cmd.acc_op   = qdmr_pkg::ACC_HOLD;
    unique case (state_r)
      qdmr_pkg::ST_TAP: begin
        in_tready    = 1'b1;
        accept       = in_tvalid;
        cmd.tap_load = accept;
        cmd.acc_op   = qdmr_pkg::ACC_PROD;
        if (accept && in_tlast) begin
          state_nxt = qdmr_pkg::ST_LASTP;
        end
      end
      qdmr_pkg::ST_LASTP: begin
        cmd.acc_op = qdmr_pkg::ACC_PROD;
        state_nxt  = qdmr_pkg::ST_BIAS;
      end
      qdmr_pkg::ST_BIAS: begin
        cmd.acc_op = qdmr_pkg::ACC_BIAS;
        state_nxt  = qdmr_pkg::ST_SHL;
      end
      qdmr_pkg::ST_SHL: begin
        cmd.a_load = 1'b1;
        cmd.acc_op = qdmr_pkg::ACC_CLEAR;
        state_nxt  = qdmr_pkg::ST_MUL;
      end
      qdmr_pkg::ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = qdmr_pkg::ST_HM;
      end
      qdmr_pkg::ST_HM: begin
        cmd.hm_en = 1'b1;
        state_nxt = qdmr_pkg::ST_RND;
      end
      qdmr_pkg::ST_RND: begin
        cmd.rnd_en = 1'b1;
        state_nxt  = qdmr_pkg::ST_OUT;
      end
      qdmr_pkg::ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = qdmr_pkg::ST_TAP;
        end
      end
      default: begin
        state_nxt = qdmr_pkg::ST_TAP;
      end
    endcase
  end

  always_comb begin
    priority if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

@@ hw/rtl/qdmr_dp.sv @@
// datapath: config registers, tap product, accumulator, requant and clamp
// depends on qdmr_pkg, driven by qdmr_ctrl commands
module qdmr_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  qdmr_pkg::dp_cmd_t                   cmd,
  input  logic                                cfg_we,
  input  logic [qdmr_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [qdmr_pkg::CfgDataW-1:0]       cfg_data,
  input  logic [qdmr_pkg::InDataW-1:0]        in_tdata,
  input  logic                                in_tuser,
  output logic [qdmr_pkg::OutDataW-1:0]       out_tdata
);

  logic [1:0]         mode_r;
  logic signed [8:0]  izp_r, wzp_r, ozp_r;
  logic               bias_en_r;

  logic [31:0]        prod_r, prod_nxt;
  logic [31:0]        acc_r, acc_nxt;
  logic [31:0]        bias_r;
  logic [30:0]        mul_r;
  logic [5:0]         sh_r;
  logic [31:0]        a_r, a_nxt;
  logic signed [63:0] p64_r, p64_nxt;
  logic [31:0]        hm_r, hm_nxt;
  logic [31:0]        v_r, v_nxt;
  logic [7:0]         out_r, out_nxt;

  logic               in_signed, w_signed;
  logic signed [9:0]  xv, wv, xd, wd;
  logic signed [19:0] p;
  logic [7:0]         in_val, w_val;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= qdmr_pkg::MODE_UNSIGNED;
      izp_r     <= '0;
      wzp_r     <= '0;
      ozp_r     <= '0;
      bias_en_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qdmr_pkg::CFG_DATA_MODE:   mode_r    <= cfg_data[1:0];
        qdmr_pkg::CFG_INPUT_ZP:    izp_r     <= cfg_data;
        qdmr_pkg::CFG_WEIGHT_ZP:   wzp_r     <= cfg_data;
        qdmr_pkg::CFG_OUTPUT_ZP:   ozp_r     <= cfg_data;
        qdmr_pkg::CFG_BIAS_ENABLE: bias_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // tap product
  always_comb begin
    in_signed = (mode_r == qdmr_pkg::MODE_SIGNED);
    w_signed  = (mode_r == qdmr_pkg::MODE_SIGNED) || (mode_r == qdmr_pkg::MODE_U_IN_S_W);
    in_val    = in_tdata[7:0];
    w_val     = in_tdata[15:8];
    xv        = {{2{in_val[7] & in_signed}}, in_val};
    wv        = {{2{w_val[7] & w_signed}}, w_val};
    xd        = xv - {izp_r[8], izp_r};
    wd        = wv - {wzp_r[8], wzp_r};
    p         = xd * wd;
    prod_nxt  = '0;
    if (cmd.tap_load && in_tuser) begin
      prod_nxt = {{12{p[19]}}, p};
    end
  end

  // accumulator
  always_comb begin
    unique case (cmd.acc_op)
      qdmr_pkg::ACC_HOLD:  acc_nxt = acc_r;
      qdmr_pkg::ACC_PROD:  acc_nxt = acc_r + prod_r;
      qdmr_pkg::ACC_BIAS:  acc_nxt = bias_en_r ? acc_r + bias_r : acc_r;
      qdmr_pkg::ACC_CLEAR: acc_nxt = '0;
      default:             acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_r <= '0;
      acc_r  <= '0;
    end else begin
      prod_r <= prod_nxt;
      acc_r  <= acc_nxt;
    end
  end

  // requant operands, latched with every tap, the last one counts
  always_ff @(posedge clk) begin
    if (cmd.tap_load) begin
      bias_r <= in_tdata[47:16];
      mul_r  <= in_tdata[78:48];
      sh_r   <= in_tdata[84:79];
    end
  end

  // left shift for negative shift, wraps mod 2^32
  logic [5:0] ls;
  always_comb begin
    ls    = (~sh_r) + 6'd1;
    a_nxt = acc_r;
    if (sh_r[5]) begin
      a_nxt = ls[5] ? 32'd0 : (acc_r << ls[4:0]);
    end
  end

  // q31 product
  assign p64_nxt = $signed(a_r) * $signed({1'b0, mul_r});

  // rounding doubling high product
  logic [63:0] hm_sum;
  always_comb begin
    hm_sum = p64_r + 64'd1073741824;
    hm_nxt = hm_sum[62:31];
  end

  // rounding right shift, half away from zero
  logic [4:0]         e;
  logic [32:0]        half, rsum;
  logic               corr;
  logic signed [32:0] rsh;
  always_comb begin
    e     = sh_r[4:0];
    half  = 33'd1 << (e - 5'd1);
    corr  = hm_r[31] && (hm_r != 32'h8000_0000);
    rsum  = {hm_r[31], hm_r} + half - {32'd0, corr};
    rsh   = $signed(rsum) >>> e;
    v_nxt = hm_r;
    if (!sh_r[5] && (e != 5'd0)) begin
      v_nxt = rsh[31:0];
    end
  end

  // output zero point and clamp
  logic signed [33:0] r, lo, hi;
  always_comb begin
    r  = $signed({{2{v_r[31]}}, v_r}) + $signed({{25{ozp_r[8]}}, ozp_r});
    lo = in_signed ? -34'sd128 : 34'sd0;
    hi = in_signed ? 34'sd127 : 34'sd255;
    priority if (r < lo) begin
      out_nxt = lo[7:0];
    end else if (r > hi) begin
      out_nxt = hi[7:0];
    end else begin
      out_nxt = r[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.a_load)   a_r   <= a_nxt;
    if (cmd.mul_en)   p64_r <= p64_nxt;
    if (cmd.hm_en)    hm_r  <= hm_nxt;
    if (cmd.rnd_en)   v_r   <= v_nxt;
    if (cmd.out_load) out_r <= out_nxt;
  end

  assign out_tdata = out_r;

endmodule

@@ hw/rtl/quantized_depthwise_mac_requant.sv @@
// channel   dir  handshake                  payload
// in_       in   in_tvalid / in_tready      in_tdata, in_tuser, in_tlast
// out_      out  out_tvalid / out_tready    out_tdata
// cfg_      in   cfg_valid / cfg_ready      cfg_index, cfg_data
//
// taps that are not last stream back to back
// after a last tap the accumulate, bias, shift, 32x32 multiply,
// high product, rounding and clamp steps run one per cycle on shared registers
// the result sits in an output register; taps of the next element are taken
// while it waits, a new last tap stalls in the clamp step until it is taken
// rst_n is synchronous; it clears the state, the accumulator and the config
//
// top level of the depthwise mac and requantizer
// depends on qdmr_pkg, qdmr_ctrl and qdmr_dp
module quantized_depthwise_mac_requant (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // input_value[7:0], weight_value[15:8], bias[47:16], multiplier[78:48],
  // shift[84:79], zero fill[87:85]
  input  logic [qdmr_pkg::InDataW-1:0]      in_tdata,
  // in_window[0]
  input  logic                              in_tuser,
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // output_value[7:0]
  output logic [qdmr_pkg::OutDataW-1:0]     out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [qdmr_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [qdmr_pkg::CfgDataW-1:0]     cfg_data
);

  qdmr_pkg::dp_cmd_t cmd;

  assign cfg_ready = 1'b1;

  qdmr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  qdmr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata)
  );

endmodule

@@ hw/rtl/qdmr_checker.sv @@
// port-level checks for the depthwise mac and requantizer
// depends on quantized_depthwise_mac_requant_assert.svh and qdmr_pkg
`include "quantized_depthwise_mac_requant_assert.svh"

module qdmr_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              in_tlast,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [qdmr_pkg::OutDataW-1:0]     out_tdata
);

  // stalled result beat stays
  `QDMR_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "out beat dropped")
  `QDMR_ASSERT(a_out_stable, out_tvalid && !out_tready |=> $stable(out_tdata), "out data moved")
  // requant sequence blocks new taps
  `QDMR_ASSERT(a_last_stall, in_tvalid && in_tready && in_tlast |=> !in_tready,
               "tap taken during requant")
  // a new result only comes out of the requant sequence
  `QDMR_ASSERT(a_out_src, $rose(out_tvalid) |-> !$past(in_tready), "result without last tap")
  `QDMR_ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_tvalid, "out valid after reset")

endmodule

bind quantized_depthwise_mac_requant qdmr_checker u_qdmr_checker (.*);
